@@ hw/rtl/disk_seek_request_scheduler_top_defines.svh @@
// Assertion macros used by the port-level checker.
`ifndef DISK_SEEK_REQUEST_SCHEDULER_TOP_DEFINES_SVH
`define DISK_SEEK_REQUEST_SCHEDULER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DSRS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define DSRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

@@ hw/rtl/dsrs_pkg.sv @@
// Package with constants and types of the disk seek request scheduler.
`timescale 1ns / 1ps
package dsrs_pkg;
   localparam int QueueDepth = 64;
   localparam int TrackBits  = 16;
   localparam int AddrBits   = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(QueueDepth + 1);
   localparam int EntryBits  = TrackBits + 16 + 1;

   localparam logic [2:0] POL_FIFO  = 3'd0;
   localparam logic [2:0] POL_SSTF  = 3'd1;
   localparam logic [2:0] POL_LOOK  = 3'd2;
   localparam logic [2:0] POL_CLOOK = 3'd3;
   localparam logic [2:0] POL_FLOOK = 3'd4;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   typedef struct packed {
      logic                 active;
      logic [15:0]          ident;
      logic [TrackBits-1:0] track;
   } entry_type;

   // Scan result handed from the selection unit to the controller.
   typedef struct packed {
      logic                 found;
      logic [AddrBits-1:0]  index;
      logic [TrackBits-1:0] track;
      logic [15:0]          ident;
   } pick_type;
endpackage

@@ hw/rtl/dsrs_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
`timescale 1ns / 1ps
module dsrs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/dsrs_picker.sv @@
// Running best-candidate tracker fed one queue entry per cycle while valid is high.
`timescale 1ns / 1ps
module dsrs_picker (
   input  logic                             clock,
   input  logic                             clear,
   input  logic                             valid,
   input  logic [dsrs_pkg::AddrBits-1:0]    index,
   input  dsrs_pkg::entry_type              entry,
   input  logic [2:0]                       policy,
   input  logic                             all_active,
   input  logic [dsrs_pkg::TrackBits-1:0]   head,
   input  logic                             moving_up,
   output dsrs_pkg::pick_type               pick
);
   // Candidates by class: direction side and any side. For C-LOOK the
   // direction class is "at or above head" and the other class keeps the
   // lowest track.
   dsrs_pkg::pick_type dir_ff, dir_in, any_ff, any_in;
   logic [dsrs_pkg::TrackBits-1:0] dir_d_ff, dir_d_in, any_d_ff, any_d_in;
   logic [dsrs_pkg::TrackBits-1:0] span;
   logic eligible, on_side, clook;

   always_comb begin
      span = (entry.track >= head) ? entry.track - head : head - entry.track;
      clook = (policy == dsrs_pkg::POL_CLOOK);
      eligible = (policy != dsrs_pkg::POL_FLOOK) || entry.active || all_active;
      if (clook) begin
         on_side = entry.track >= head;
      end else begin
         on_side = moving_up ? (entry.track >= head) : (entry.track <= head);
      end
      dir_in = dir_ff;
      dir_d_in = dir_d_ff;
      any_in = any_ff;
      any_d_in = any_d_ff;
      if (clear) begin
         dir_in = '0;
         any_in = '0;
         dir_d_in = '0;
         any_d_in = '0;
      end else if (valid && eligible) begin
         if (on_side && (!dir_ff.found || span < dir_d_ff)) begin
            dir_in = '{found: 1'b1, index: index, track: entry.track, ident: entry.ident};
            dir_d_in = span;
         end
         if (!any_ff.found ||
             (clook ? (entry.track < any_ff.track) : (span < any_d_ff))) begin
            any_in = '{found: 1'b1, index: index, track: entry.track, ident: entry.ident};
            any_d_in = span;
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff <= dir_in;
      any_ff <= any_in;
      dir_d_ff <= dir_d_in;
      any_d_ff <= any_d_in;
   end

   always_comb begin
      if (policy == dsrs_pkg::POL_SSTF) begin
         pick = any_ff;
      end else begin
         pick = dir_ff.found ? dir_ff : any_ff;
      end
   end
endmodule

@@ hw/rtl/disk_seek_request_scheduler_top.sv @@
// Top level of the disk seek request scheduler.
`timescale 1ns / 1ps
// Disk-arm request scheduler. The req_ channel carries transactions: kind 0
// adds a request (track, id) to an arrival-ordered queue, kind 1 fetches one
// request chosen by the policy register. Each transaction yields exactly one
// rsp_ transaction. The csr_ channel writes the policy while the block idles.
// The queue lives in one RAM of QueueDepth entries with a registered read.
// With n queued entries, an add or a fetch from an empty queue is answered
// directly; a FIFO fetch reads the oldest entry and then only closes the
// gap that it leaves; SSTF, LOOK and C-LOOK scan all n entries and then
// move every later entry down one slot. F-LOOK adds a first pass over the
// n entries that looks for an active entry; when none is found, the closing
// pass rewrites every remaining entry with its active bit set.
// A new request can be taken in the cycle after the result has been accepted.
// Reset empties the queue, puts the head at track 0 moving up and the
// policy to FIFO; the RAM contents need no clearing. One transaction is in
// flight at a time: req_ready stays low until the result has been taken, so
// a stalled receiver simply holds the block in its result state.
module disk_seek_request_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_req_track,
   input  logic [15:0] req_req_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_granted,
   output logic [15:0] rsp_grant_id,
   output logic [15:0] rsp_grant_track,
   output logic [15:0] rsp_seek_distance,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_policy
);
   localparam int AB = dsrs_pkg::AddrBits;
   localparam int CB = dsrs_pkg::CountBits;
   localparam int TB = dsrs_pkg::TrackBits;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ACT   = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_DONE  = 7'b0001000,
      ST_SHIFT = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CB-1:0] fill_ff, fill_in;
   logic [TB-1:0] head_ff, head_in;
   logic up_ff, up_in;
   logic [2:0] policy_ff;
   logic [CB-1:0] rd_ff, rd_in;       // next read address
   logic pend_ff, pend_in;            // a read issued last cycle
   logic [AB-1:0] pend_idx_ff, pend_idx_in;
   logic any_act_ff, any_act_in;
   logic all_act_ff, all_act_in;
   logic [AB-1:0] k_ff, k_in;
   logic acc_ff, acc_in, gr_ff, gr_in;
   logic [15:0] gid_ff, gid_in, gtr_ff, gtr_in, gdist_ff, gdist_in;

   logic wr_en;
   logic [AB-1:0] wr_addr, rd_addr;
   dsrs_pkg::entry_type wr_data, rd_data;
   dsrs_pkg::pick_type pick;
   logic pclear, pvalid;
   logic [TB-1:0] pt;

   dsrs_ram #(.Width(dsrs_pkg::EntryBits), .Depth(dsrs_pkg::QueueDepth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   dsrs_picker u_pick (
      .clock(clock), .clear(pclear), .valid(pvalid), .index(pend_idx_ff),
      .entry(rd_data), .policy(policy_ff), .all_active(all_act_ff),
      .head(head_ff), .moving_up(up_ff), .pick(pick)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_accepted = acc_ff;
   assign rsp_granted = gr_ff;
   assign rsp_grant_id = gid_ff;
   assign rsp_grant_track = gtr_ff;
   assign rsp_seek_distance = gdist_ff;
   assign rd_addr = rd_ff[AB-1:0];
   assign pt = pick.track;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      head_in = head_ff;
      up_in = up_ff;
      rd_in = rd_ff;
      pend_in = 1'b0;
      pend_idx_in = rd_ff[AB-1:0];
      any_act_in = any_act_ff;
      all_act_in = all_act_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      gr_in = gr_ff;
      gid_in = gid_ff;
      gtr_in = gtr_ff;
      gdist_in = gdist_ff;
      wr_en = 1'b0;
      wr_addr = fill_ff[AB-1:0];
      wr_data = '{active: 1'b0, ident: req_req_id, track: req_req_track[TB-1:0]};
      pclear = 1'b0;
      pvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pclear = 1'b1;
            rd_in = '0;
            any_act_in = 1'b0;
            all_act_in = 1'b0;
            if (req_valid) begin
               acc_in = 1'b0;
               gr_in = 1'b0;
               gid_in = '0;
               gtr_in = '0;
               gdist_in = '0;
               if (req_kind == dsrs_pkg::KIND_ADD) begin
                  if (fill_ff != CB'(dsrs_pkg::QueueDepth)) begin
                     wr_en = 1'b1;
                     fill_in = fill_ff + CB'(1);
                     acc_in = 1'b1;
                  end
                  state_in = ST_RESP;
               end else if (fill_ff == '0) begin
                  state_in = ST_RESP;
               end else if (policy_ff == dsrs_pkg::POL_FLOOK) begin
                  state_in = ST_ACT;
               end else if (policy_ff == dsrs_pkg::POL_SSTF ||
                            policy_ff == dsrs_pkg::POL_LOOK ||
                            policy_ff == dsrs_pkg::POL_CLOOK) begin
                  state_in = ST_SCAN;
               end else begin
                  // FIFO and unused codes: the oldest entry, read directly.
                  pend_in = 1'b1;
                  pend_idx_in = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_ACT: begin
            // Look for any active entry.
            if (pend_ff) begin
               if (rd_data.active) any_act_in = 1'b1;
            end
            if (rd_ff < fill_ff) begin
               pend_in = 1'b1;
               rd_in = rd_ff + CB'(1);
            end else if (!pend_ff) begin
               all_act_in = !any_act_ff;
               rd_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff) pvalid = 1'b1;
            if (rd_ff < fill_ff) begin
               pend_in = 1'b1;
               rd_in = rd_ff + CB'(1);
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Result comes from the picker, or from the direct FIFO read.
            if (pend_ff) begin
               k_in = '0;
               gid_in = rd_data.ident;
               gtr_in = 16'(rd_data.track);
               head_in = rd_data.track;
               gdist_in = 16'((rd_data.track >= head_ff) ? rd_data.track - head_ff
                                                         : head_ff - rd_data.track);
               if (rd_data.track > head_ff) up_in = 1'b1;
               else if (rd_data.track < head_ff) up_in = 1'b0;
            end else begin
               k_in = pick.index;
               gid_in = pick.ident;
               gtr_in = 16'(pt);
               head_in = pt;
               gdist_in = 16'((pt >= head_ff) ? pt - head_ff : head_ff - pt);
               if (pt > head_ff) up_in = 1'b1;
               else if (pt < head_ff) up_in = 1'b0;
            end
            gr_in = 1'b1;
            // When every entry was just made active, the pass starts at the
            // bottom so that entries below the served one get their bit too.
            if (all_act_ff) begin
               rd_in = '0;
            end else begin
               rd_in = (pend_ff ? CB'(0) : CB'(pick.index)) + CB'(1);
            end
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // Entries below k are rewritten in place, entries above k move
            // down one slot, and the served entry itself is dropped.
            if (pend_ff) begin
               wr_data = rd_data;
               if (all_act_ff) wr_data.active = 1'b1;
               if (pend_idx_ff < k_ff) begin
                  wr_en = 1'b1;
                  wr_addr = pend_idx_ff;
               end else if (pend_idx_ff > k_ff) begin
                  wr_en = 1'b1;
                  wr_addr = pend_idx_ff - AB'(1);
               end
            end
            if (rd_ff < fill_ff) begin
               pend_in = 1'b1;
               rd_in = rd_ff + CB'(1);
            end else if (!pend_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            fill_in = fill_ff - CB'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // The next FIFO fetch reads address zero straight from idle.
            rd_in = '0;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         head_ff <= '0;
         up_ff <= 1'b1;
         policy_ff <= dsrs_pkg::POL_FIFO;
         rd_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         head_ff <= head_in;
         up_ff <= up_in;
         rd_ff <= rd_in;
         pend_ff <= pend_in;
         if (csr_valid && csr_ready) policy_ff <= csr_policy;
      end
      pend_idx_ff <= pend_idx_in;
      any_act_ff <= any_act_in;
      all_act_ff <= all_act_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      gr_ff <= gr_in;
      gid_ff <= gid_in;
      gtr_ff <= gtr_in;
      gdist_ff <= gdist_in;
   end
endmodule

@@ hw/rtl/dsrs_checker.sv @@
// Port-level checker bound to the scheduler top level.
`timescale 1ns / 1ps
`include "disk_seek_request_scheduler_top_defines.svh"
module dsrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_granted,
   input logic [15:0] rsp_grant_id,
   input logic [15:0] rsp_seek_distance
);
   `DSRS_ASSERT_IMP(a_no_both, clock, reset, rsp_valid, !(rsp_accepted && rsp_granted))
   `DSRS_ASSERT_IMP(a_idle_excl, clock, reset, rsp_valid, !req_ready)
   `DSRS_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_granted,
      rsp_grant_id == 16'd0 && rsp_seek_distance == 16'd0)
   `DSRS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_grant_id))
   // An add is answered in the very next cycle.
   `DSRS_ASSERT_NEXT(a_add_fast, clock, reset,
      req_valid && req_ready && req_kind == dsrs_pkg::KIND_ADD, rsp_valid)
endmodule

bind disk_seek_request_scheduler_top dsrs_checker u_dsrs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_accepted(rsp_accepted), .rsp_granted(rsp_granted),
   .rsp_grant_id(rsp_grant_id), .rsp_seek_distance(rsp_seek_distance)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the disk seek request scheduler.
`timescale 1ns / 1ps
module tb_top;
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic        accepted;
      logic        granted;
      logic [15:0] grant_id;
      logic [15:0] grant_track;
      logic [15:0] seek_distance;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = dsrs_pkg::KIND_ADD;
   logic [15:0] req_req_track = '0;
   logic [15:0] req_req_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic        rsp_granted;
   logic [15:0] rsp_grant_id;
   logic [15:0] rsp_grant_track;
   logic [15:0] rsp_seek_distance;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_policy = dsrs_pkg::POL_FIFO;

   // Shadow copy of the scheduler state.
   logic [15:0] q_track[$];
   logic [15:0] q_ident[$];
   logic        q_active[$];
   logic [15:0] head_pos;
   logic        going_up;
   logic [2:0]  cur_policy;

   grant_type   pending_grants[$];
   int          mismatches = 0;
   int          sent = 0;
   int          fetches = 0;
   int          rsp_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_rsp = 1'b0;

   disk_seek_request_scheduler_top u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] seek_len(logic [15:0] t);
      return (t >= head_pos) ? t - head_pos : head_pos - t;
   endfunction

   // Nearest qualifying entry, earliest wins ties; returns -1 when none.
   function automatic int closest_entry(bit only_active, bit same_side);
      int best = -1;
      logic [15:0] best_d = '0;
      for (int i = 0; i < q_track.size(); i++) begin
         if (only_active && !q_active[i]) continue;
         if (same_side && (going_up ? q_track[i] < head_pos : q_track[i] > head_pos))
            continue;
         if (best < 0 || seek_len(q_track[i]) < best_d) begin
            best = i;
            best_d = seek_len(q_track[i]);
         end
      end
      return best;
   endfunction

   function automatic int sweep_pick(bit only_active);
      int k = closest_entry(only_active, 1'b1);
      if (k < 0) k = closest_entry(only_active, 1'b0);
      return k;
   endfunction

   function automatic int circular_pick();
      int best = -1;
      for (int i = 0; i < q_track.size(); i++)
         if (q_track[i] >= head_pos &&
             (best < 0 || q_track[i] < q_track[best])) best = i;
      if (best >= 0) return best;
      best = 0;
      for (int i = 1; i < q_track.size(); i++)
         if (q_track[i] < q_track[best]) best = i;
      return best;
   endfunction

   function automatic grant_type schedule(logic kind, logic [15:0] trk, logic [15:0] id);
      grant_type g = '0;
      int k;
      if (kind == dsrs_pkg::KIND_ADD) begin
         if (q_track.size() < dsrs_pkg::QueueDepth) begin
            q_track = {q_track, trk};
            q_ident = {q_ident, id};
            q_active = {q_active, 1'b0};
            g.accepted = 1'b1;
         end
         return g;
      end
      if (q_track.size() == 0) return g;
      case (cur_policy)
         dsrs_pkg::POL_SSTF:  k = closest_entry(1'b0, 1'b0);
         dsrs_pkg::POL_LOOK:  k = sweep_pick(1'b0);
         dsrs_pkg::POL_CLOOK: k = circular_pick();
         dsrs_pkg::POL_FLOOK: begin
            if (closest_entry(1'b1, 1'b0) < 0)
               foreach (q_active[i]) q_active[i] = 1'b1;
            k = sweep_pick(1'b1);
         end
         default:   k = 0;
      endcase
      if (k < 0) k = 0;
      g.granted = 1'b1;
      g.grant_id = q_ident[k];
      g.grant_track = q_track[k];
      g.seek_distance = seek_len(q_track[k]);
      if (q_track[k] > head_pos) going_up = 1'b1;
      else if (q_track[k] < head_pos) going_up = 1'b0;
      head_pos = q_track[k];
      q_track.delete(k);
      q_ident.delete(k);
      q_active.delete(k);
      return g;
   endfunction

   // Each transaction starts on a clock edge after the previous one ended, so
   // the block, which is never ready right after an acceptance, loses nothing.
   task automatic send_request(logic kind, logic [15:0] trk, logic [15:0] id);
      @(posedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         @(posedge clock);
      pending_grants = {pending_grants, schedule(kind, trk, id)};
      if (kind == dsrs_pkg::KIND_FETCH) fetches++;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_req_track <= trk;
      req_req_id <= id;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      sent++;
   endtask

   task automatic drain_results();
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_policy(logic [2:0] pol);
      drain_results();
      csr_valid <= 1'b1;
      csr_policy <= pol;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_policy = pol;
   endtask

   // Tracks are drawn often from a narrow band so that ties and equal heads occur.
   function automatic logic [15:0] pick_track();
      case ($urandom_range(3))
         0: return 16'($urandom_range(8));
         1: return 16'($urandom);
         2: return 16'hFFFF - 16'($urandom_range(3));
         default: return head_pos + 16'($urandom_range(6)) - 16'd3;
      endcase
   endfunction

   task automatic run_random(int count, int add_pct);
      for (int n = 0; n < count; n++)
         send_request(($urandom_range(99) < add_pct) ? dsrs_pkg::KIND_ADD
                                                     : dsrs_pkg::KIND_FETCH,
                      pick_track(), 16'($urandom));
   endtask

   task automatic test_directed();
      send_request(dsrs_pkg::KIND_FETCH, 16'h0, 16'h0);
      send_request(dsrs_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF);
      send_request(dsrs_pkg::KIND_ADD, 16'h0000, 16'h0000);
      send_request(dsrs_pkg::KIND_ADD, 16'hFFFF, 16'h5555);
      send_request(dsrs_pkg::KIND_ADD, 16'h8000, 16'hAAAA);
      for (int i = 0; i < 5; i++) send_request(dsrs_pkg::KIND_FETCH, 16'h0, 16'h0);
   endtask

   // Fills past capacity to see a rejected add, then empties the queue.
   task automatic test_full_queue();
      for (int i = 0; i < dsrs_pkg::QueueDepth + 3; i++)
         send_request(dsrs_pkg::KIND_ADD, pick_track(), 16'(i));
      for (int i = 0; i < dsrs_pkg::QueueDepth + 1; i++)
         send_request(dsrs_pkg::KIND_FETCH, 16'h0, 16'h0);
   endtask

   task automatic test_policies();
      logic [2:0] pols[8] = '{dsrs_pkg::POL_FIFO, dsrs_pkg::POL_SSTF, dsrs_pkg::POL_LOOK,
                              dsrs_pkg::POL_CLOOK, dsrs_pkg::POL_FLOOK,
                              3'd5, 3'd7, dsrs_pkg::POL_FLOOK};
      foreach (pols[p]) begin
         write_policy(pols[p]);
         run_random(120, 60);
         run_random(60, 30);
      end
   endtask

   task automatic test_idling();
      int phases[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{22, 22}};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phases[ph][0];
         recv_stall_pct = phases[ph][1];
         write_policy(3'($urandom_range(dsrs_pkg::POL_FLOOK)));
         run_random(80, 55);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // The receiver blocks for a long time while requests keep coming.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         run_random(20, 70);
      join
   endtask

   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      grant_type seen;
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_accepted, rsp_granted, rsp_grant_id, rsp_grant_track,
                 rsp_seek_distance};
         rsp_count++;
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", seen);
         end else begin
            want = pending_grants.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, seen);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      head_pos = '0;
      going_up = 1'b1;
      cur_policy = dsrs_pkg::POL_FIFO;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_queue();
      test_policies();
      test_idling();
      test_backpressure();
      drain_results();
      if (pending_grants.size() != 0) mismatches++;
      $display("Ran %0d transactions (%0d fetches, %0d results checked) across all policies,",
               sent, fetches, rsp_count);
      $display("a full queue, idle and stall phases and a long receiver hold.");
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dsrs_pkg.sv
hw/rtl/dsrs_ram.sv
hw/rtl/dsrs_picker.sv
hw/rtl/disk_seek_request_scheduler_top.sv
hw/rtl/dsrs_checker.sv
tb/sv/tb_top.sv
